// ===== src/video_sync_timer_with_register_file_assert.svh =====
// assertion helpers shared by the vstr modules
`ifndef VIDEO_SYNC_TIMER_WITH_REGISTER_FILE_ASSERT_SVH
`define VIDEO_SYNC_TIMER_WITH_REGISTER_FILE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define VSTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define VSTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/vstr_pkg.sv =====
package vstr_pkg;

    localparam int REG_WORDS_DEF = 8192;
    localparam int ADDR_MAX_W    = 13;
    localparam int ALU_W         = 34;
    localparam int DIV_W         = 14;
    localparam int REM_W         = 13;
    localparam int BIT_W         = 4;
    localparam int CFG_DATA_W    = 24;

    // restoring remainder: first shift for scanline wrap
    localparam logic [BIT_W-1:0] MOD_SL_TOP  = 4'd10;

    localparam logic [DIV_W-1:0] LINES_WRAP = 14'd1024;

    localparam logic [31:0] ID_WORD       = 32'h17fd11db;
    localparam logic [31:0] REV_WORD      = 32'h0000_0011;
    localparam logic [31:0] STATUS_VBLANK = 32'h0000_2000;
    localparam logic [31:0] LA_SAT        = 32'h7fff_ffff;

    localparam logic [15:0] ADDR_ID   = 16'h8000;
    localparam logic [15:0] ADDR_REV  = 16'h8004;
    localparam logic [15:0] ADDR_SYNC = 16'h810C;

    localparam logic [14:0] ADDR_SOFT_RESET   = 15'h0008;
    localparam logic [14:0] ADDR_START_RENDER = 15'h0014;
    localparam logic [14:0] ADDR_LIST_INIT    = 15'h0144;

    // word indices of the registers with side effects
    localparam int W_RASTER   = 'h0CC >> 2;
    localparam int W_STATUS   = 'h10C >> 2;
    localparam int W_OL_BASE  = 'h124 >> 2;
    localparam int W_ISP_BASE = 'h128 >> 2;
    localparam int W_NEXT_OPB = 'h134 >> 2;
    localparam int W_ITP_CUR  = 'h138 >> 2;
    localparam int W_OPB_INIT = 'h164 >> 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_FRAME_CYCLES = 2'd0,
        CFG_LINES        = 2'd1,
        CFG_LINE_THR     = 2'd2,
        CFG_LINE_STEP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] frame_cycles;
        logic [9:0]  lines_per_frame;
        logic [15:0] line_threshold;
        logic [15:0] line_step;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_cycles:    24'd3333333,
        lines_per_frame: 10'd521,
        line_threshold:  16'd6397,
        line_step:       16'd6708
    };

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             neg;
        logic             zero;
    } t_alu_rsp;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [ADDR_MAX_W-1:0] addr;
        logic [31:0]           wdata;
    } t_mem_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_FA_ADD,
        S_FA_SUB,
        S_ST_RD,
        S_ST_WR,
        S_LA_ADD,
        S_LA_CMP,
        S_LA_STEP,
        S_SL_INC,
        S_RD_ISSUE,
        S_RD_DATA,
        S_CP_RD_ISP,
        S_CP_WR_ITP,
        S_CP_RD_OPB,
        S_CP_WR_OL,
        S_CP_WR_NOPB,
        S_WR,
        S_DONE
    } t_state;

endpackage

// ===== src/vstr_in_if.sv =====
interface vstr_in_if import vstr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] reg_address;
    logic [31:0] write_value;
    logic [15:0] tick_cycles;

    modport source (output valid, opcode, reg_address, write_value, tick_cycles,
                    input ready);
    modport sink (input valid, opcode, reg_address, write_value, tick_cycles,
                  output ready);
endinterface

// ===== src/vstr_out_if.sv =====
interface vstr_out_if import vstr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic        frame_irq;
    logic        scan_irq_one;
    logic        scan_irq_two;

    modport source (output valid, read_value, frame_irq, scan_irq_one, scan_irq_two,
                    input ready);
    modport sink (input valid, read_value, frame_irq, scan_irq_one, scan_irq_two,
                  output ready);
endinterface

// ===== src/vstr_alu.sv =====
module vstr_alu import vstr_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] sum;

    assign sum        = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
    assign o_rsp.y    = sum;
    assign o_rsp.neg  = sum[ALU_W-1];
    assign o_rsp.zero = (sum == '0);

endmodule

// ===== src/vstr_store.sv =====
`include "video_sync_timer_with_register_file_assert.svh"

module vstr_store import vstr_pkg::*; #(
    parameter int REG_WORDS = REG_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata,
    output logic        o_clear_busy
);

    localparam int            AW   = $clog2(REG_WORDS);
    localparam logic [AW-1:0] LAST = AW'(REG_WORDS - 1);

    logic [31:0]   r_mem [REG_WORDS];
    logic [31:0]   r_rdata;
    logic          r_clearing, n_clearing;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;

    // clearing pass owns the port until every word is zero
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_req.en && i_req.we;
            wr_addr = i_req.addr[AW-1:0];
            wr_data = i_req.wdata;
        end
        rd_en      = i_req.en && !i_req.we && !r_clearing;
        n_clearing = r_clearing && (r_clr_addr != LAST);
        n_clr_addr = r_clearing ? (r_clr_addr + AW'(1)) : r_clr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_clear_busy = r_clearing;

    `VSTR_ASSERT_IMP(a_no_req_clear, i_clk, i_rst_n, r_clearing, !i_req.en,
        "store access during clearing pass")
    `VSTR_ASSERT_IMP(a_we_has_en, i_clk, i_rst_n, i_req.we, i_req.en,
        "write strobe without enable")
    `VSTR_ASSERT_IMP(a_addr_range, i_clk, i_rst_n, i_req.en,
        {1'b0, i_req.addr} < (ADDR_MAX_W + 1)'(REG_WORDS), "store address past depth")
    `VSTR_ASSERT_IMP(a_clear_full, i_clk, i_rst_n, $fell(r_clearing),
        $past(r_clr_addr) == LAST, "clearing pass ended early")

endmodule

// ===== src/vstr_ctrl.sv =====
`include "video_sync_timer_with_register_file_assert.svh"

module vstr_ctrl import vstr_pkg::*; #(
    parameter int REG_WORDS = REG_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_clear_busy,
    output t_mem_req    o_mem_req,
    input  logic [31:0] i_mem_rdata,
    output t_alu_req    o_alu_req,
    input  t_alu_rsp    i_alu_rsp,
    vstr_in_if.sink     in_ch,
    vstr_out_if.source  out_ch
);

    localparam logic [ADDR_MAX_W-1:0] IDX_RASTER   = ADDR_MAX_W'(W_RASTER % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_STATUS   = ADDR_MAX_W'(W_STATUS % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_OL_BASE  = ADDR_MAX_W'(W_OL_BASE % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_ISP_BASE = ADDR_MAX_W'(W_ISP_BASE % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_NEXT_OPB = ADDR_MAX_W'(W_NEXT_OPB % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_ITP_CUR  = ADDR_MAX_W'(W_ITP_CUR % REG_WORDS);
    localparam logic [ADDR_MAX_W-1:0] IDX_OPB_INIT = ADDR_MAX_W'(W_OPB_INIT % REG_WORDS);

    // word index modulo the store depth by reciprocal multiplication,
    // exact for every 13-bit word address
    localparam int          IDX_SH    = 26;
    localparam logic [17:0] IDX_RECIP = 18'(((64'd1 << IDX_SH) + 64'(REG_WORDS) - 64'd1)
                                            / 64'(REG_WORDS));

    t_state r_state, n_state;

    // latched transaction
    t_op         r_op, n_op;
    logic [15:0] r_addr, n_addr;
    logic [31:0] r_data, n_data;
    logic [15:0] r_cyc, n_cyc;

    // timing state
    logic [31:0] r_fa, n_fa;
    logic [31:0] r_la, n_la;
    logic [9:0]  r_sl, n_sl;
    logic [31:0] r_raster, n_raster;

    // scratch for the shared unit
    logic [31:0]           r_tmp, n_tmp;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_div, n_div;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [ADDR_MAX_W-1:0] r_idx, n_idx;

    // result being built and output register
    logic [31:0] r_rd, n_rd;
    logic        r_fi, n_fi, r_s1, n_s1, r_s2, n_s2;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_rd, n_out_rd;
    logic        r_out_fi, n_out_fi, r_out_s1, n_out_s1, r_out_s2, n_out_s2;

    logic             accept;
    logic             alu_gt;
    logic [ALU_W-1:0] la_ext;
    logic [14:0]      low_addr;
    logic             wr_zero;
    logic             list_init;
    logic [31:0]      wval;
    logic [13:0]      sl_ext;
    logic             vblank;
    logic [REM_W-1:0] rem_nxt;
    logic             slot_free;

    logic [IDX_SH+4:0]     idx_prod;
    logic [4:0]            idx_quo;
    logic [ADDR_MAX_W-1:0] idx_mod;

    assign accept    = in_ch.valid && in_ch.ready;
    assign alu_gt    = !i_alu_rsp.neg && !i_alu_rsp.zero;
    assign la_ext    = {{(ALU_W - 32){r_la[31]}}, r_la};
    assign low_addr  = {r_addr[14:2], 2'b00};
    assign wr_zero   = (low_addr == ADDR_SOFT_RESET) || (low_addr == ADDR_START_RENDER)
                       || (low_addr == ADDR_LIST_INIT);
    assign list_init = (low_addr == ADDR_LIST_INIT) && r_data[31];
    assign wval      = wr_zero ? '0 : r_data;
    assign sl_ext    = {4'b0000, r_sl};
    assign vblank    = (r_raster != '0)
                       && ((sl_ext <= r_raster[29:16]) || (sl_ext >= r_raster[13:0]));
    assign rem_nxt   = i_alu_rsp.neg ? r_rem : i_alu_rsp.y[REM_W-1:0];
    assign slot_free = !r_out_valid || out_ch.ready;

    // quotient of the word address by the depth, then the remainder
    assign idx_prod = (IDX_SH+5)'(r_addr[14:2]) * (IDX_SH+5)'(IDX_RECIP);
    assign idx_quo  = idx_prod[IDX_SH+4:IDX_SH];
    assign idx_mod  = r_addr[14:2] - ADDR_MAX_W'(32'(idx_quo) * 32'(REG_WORDS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (accept) n_state = S_DECODE;
            S_DECODE: begin
                unique case (r_op)
                    OP_TICK:  n_state = S_FA_ADD;
                    OP_READ:  n_state = S_RD_ISSUE;
                    OP_WRITE: n_state = list_init ? S_CP_RD_ISP : S_WR;
                    default:  n_state = S_DONE;
                endcase
            end
            S_FA_ADD:     n_state = S_FA_SUB;
            S_FA_SUB:     n_state = alu_gt ? S_ST_RD : S_LA_ADD;
            S_ST_RD:      n_state = S_ST_WR;
            S_ST_WR:      n_state = S_LA_ADD;
            S_LA_ADD:     n_state = S_LA_CMP;
            S_LA_CMP:     n_state = alu_gt ? S_LA_STEP : S_DONE;
            S_LA_STEP:    n_state = S_SL_INC;
            S_SL_INC:     n_state = S_MOD;
            S_MOD:        if (r_bit == '0) n_state = S_DONE;
            S_RD_ISSUE:   n_state = S_RD_DATA;
            S_RD_DATA:    n_state = S_DONE;
            S_CP_RD_ISP:  n_state = S_CP_WR_ITP;
            S_CP_WR_ITP:  n_state = S_CP_RD_OPB;
            S_CP_RD_OPB:  n_state = S_CP_WR_OL;
            S_CP_WR_OL:   n_state = S_CP_WR_NOPB;
            S_CP_WR_NOPB: n_state = S_WR;
            S_WR:         n_state = S_DONE;
            S_DONE:       if (slot_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_alu_req = '0;
        o_mem_req = '0;
        n_op      = r_op;
        n_addr    = r_addr;
        n_data    = r_data;
        n_cyc     = r_cyc;
        n_fa      = r_fa;
        n_la      = r_la;
        n_sl      = r_sl;
        n_raster  = r_raster;
        n_tmp     = r_tmp;
        n_rem     = r_rem;
        n_div     = r_div;
        n_bit     = r_bit;
        n_idx     = r_idx;
        n_rd      = r_rd;
        n_fi      = r_fi;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_out_rd  = r_out_rd;
        n_out_fi  = r_out_fi;
        n_out_s1  = r_out_s1;
        n_out_s2  = r_out_s2;
        n_out_valid = r_out_valid && !out_ch.ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = t_op'(in_ch.opcode);
                    n_addr = in_ch.reg_address;
                    n_data = in_ch.write_value;
                    n_cyc  = in_ch.tick_cycles;
                end
            end
            S_DECODE: begin
                n_rd  = '0;
                n_fi  = 1'b0;
                n_s1  = 1'b0;
                n_s2  = 1'b0;
                n_idx = idx_mod;
            end
            S_FA_ADD: begin
                o_alu_req.a = ALU_W'(r_fa);
                o_alu_req.b = ALU_W'(r_cyc);
                n_tmp = i_alu_rsp.y[32] ? '1 : i_alu_rsp.y[31:0];
            end
            S_FA_SUB: begin
                o_alu_req.a   = ALU_W'(r_tmp);
                o_alu_req.b   = ALU_W'(i_cfg.frame_cycles);
                o_alu_req.sub = 1'b1;
                if (alu_gt) begin
                    n_fa = i_alu_rsp.y[31:0];
                    n_fi = 1'b1;
                end else begin
                    n_fa = r_tmp;
                end
            end
            S_ST_RD: begin
                o_mem_req.en   = 1'b1;
                o_mem_req.addr = IDX_STATUS;
            end
            S_ST_WR: begin
                o_mem_req.en    = 1'b1;
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = IDX_STATUS;
                o_mem_req.wdata = i_mem_rdata | STATUS_VBLANK;
            end
            S_LA_ADD: begin
                o_alu_req.a = la_ext;
                o_alu_req.b = ALU_W'(r_cyc);
                // clamp at the largest positive 32-bit value
                if (!i_alu_rsp.y[ALU_W-1] && (i_alu_rsp.y[32:31] != 2'b00)) begin
                    n_la = LA_SAT;
                end else begin
                    n_la = i_alu_rsp.y[31:0];
                end
            end
            S_LA_CMP: begin
                o_alu_req.a   = la_ext;
                o_alu_req.b   = ALU_W'(i_cfg.line_threshold);
                o_alu_req.sub = 1'b1;
            end
            S_LA_STEP: begin
                o_alu_req.a   = la_ext;
                o_alu_req.b   = ALU_W'(i_cfg.line_step);
                o_alu_req.sub = 1'b1;
                n_la = i_alu_rsp.y[31:0];
            end
            S_SL_INC: begin
                o_alu_req.a = ALU_W'(r_sl);
                o_alu_req.b = ALU_W'(1);
                n_rem = i_alu_rsp.y[REM_W-1:0];
                n_div = (i_cfg.lines_per_frame == '0) ? LINES_WRAP
                                                      : DIV_W'(i_cfg.lines_per_frame);
                n_bit = MOD_SL_TOP;
            end
            S_MOD: begin
                // one restoring remainder step per cycle
                o_alu_req.a   = ALU_W'(r_rem);
                o_alu_req.b   = ALU_W'(r_div) << r_bit;
                o_alu_req.sub = 1'b1;
                n_rem = rem_nxt;
                if (r_bit != '0) begin
                    n_bit = r_bit - BIT_W'(1);
                end else begin
                    n_sl = rem_nxt[9:0];
                    n_s1 = (r_raster[13:0] == {4'b0000, rem_nxt[9:0]});
                    n_s2 = (r_raster[29:16] == {4'b0000, rem_nxt[9:0]});
                end
            end
            S_RD_ISSUE: begin
                o_mem_req.en   = 1'b1;
                o_mem_req.addr = r_idx;
            end
            S_RD_DATA: begin
                if (r_addr == ADDR_ID) begin
                    n_rd = ID_WORD;
                end else if (r_addr == ADDR_REV) begin
                    n_rd = REV_WORD;
                end else if (r_addr == ADDR_SYNC) begin
                    n_rd = (vblank ? STATUS_VBLANK : '0) | 32'(r_sl);
                end else begin
                    n_rd = i_mem_rdata;
                end
            end
            S_CP_RD_ISP: begin
                o_mem_req.en   = 1'b1;
                o_mem_req.addr = IDX_ISP_BASE;
            end
            S_CP_WR_ITP: begin
                o_mem_req.en    = 1'b1;
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = IDX_ITP_CUR;
                o_mem_req.wdata = i_mem_rdata;
            end
            S_CP_RD_OPB: begin
                o_mem_req.en   = 1'b1;
                o_mem_req.addr = IDX_OPB_INIT;
            end
            S_CP_WR_OL: begin
                o_mem_req.en    = 1'b1;
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = IDX_OL_BASE;
                o_mem_req.wdata = i_mem_rdata;
            end
            S_CP_WR_NOPB: begin
                o_mem_req.en    = 1'b1;
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = IDX_NEXT_OPB;
                o_mem_req.wdata = i_mem_rdata;
            end
            S_WR: begin
                o_mem_req.en    = 1'b1;
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = r_idx;
                o_mem_req.wdata = wval;
                if (r_idx == IDX_RASTER) begin
                    n_raster = wval;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_rd;
                    n_out_fi    = r_fi;
                    n_out_s1    = r_s1;
                    n_out_s2    = r_s2;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fa        <= '0;
            r_la        <= '0;
            r_sl        <= '0;
            r_raster    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fa        <= n_fa;
            r_la        <= n_la;
            r_sl        <= n_sl;
            r_raster    <= n_raster;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_data   <= n_data;
        r_cyc    <= n_cyc;
        r_tmp    <= n_tmp;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_bit    <= n_bit;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
        r_fi     <= n_fi;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_out_rd <= n_out_rd;
        r_out_fi <= n_out_fi;
        r_out_s1 <= n_out_s1;
        r_out_s2 <= n_out_s2;
    end

    assign in_ch.ready         = (r_state == S_IDLE) && !i_clear_busy;
    assign out_ch.valid        = r_out_valid;
    assign out_ch.read_value   = r_out_rd;
    assign out_ch.frame_irq    = r_out_fi;
    assign out_ch.scan_irq_one = r_out_s1;
    assign out_ch.scan_irq_two = r_out_s2;

    `VSTR_ASSERT_NXT(a_accept_decode, i_clk, i_rst_n, accept, r_state == S_DECODE,
        "accepted transaction did not reach decode")
    `VSTR_ASSERT_IMP(a_mod_bit_range, i_clk, i_rst_n, r_state == S_MOD,
        r_bit <= MOD_SL_TOP, "remainder step count out of range")
    `VSTR_ASSERT_IMP(a_status_rmw, i_clk, i_rst_n, r_state == S_ST_WR,
        $past(r_state) == S_ST_RD, "status update without preceding read")
    `VSTR_ASSERT_IMP(a_copy_after_read, i_clk, i_rst_n, r_state == S_CP_WR_OL,
        $past(r_state) == S_CP_RD_OPB, "list init copy without preceding read")

endmodule

// ===== src/video_sync_timer_with_register_file.sv =====
// video sync timer with a word register store
// channels: in_ch carries one transaction (tick, register read, register write);
// out_ch returns exactly one result transaction for each, in order
// configuration: i_cfg_we writes i_cfg_wdata into the register picked by i_cfg_idx
// (frame cycles, lines per frame, line threshold, line step), no read-back
// from accept to result valid the sequencer steps the shared adder through states:
//   tick: frame add and subtract, status read and write when a frame elapses, line
//   add and compare, then line step, scanline increment and the restoring remainder
//   that wraps the scanline when it advances; read: issue, data; write: store write;
//   list-init: copies then the write (single store port); unused opcode: result only
// one transaction is in flight at a time; the next is taken in the cycle after the
// result is loaded into the output register
// reset: sync, active low; config returns to defaults, timing state clears, and a
// clearing pass zeros the store one word per cycle, in_ch not ready meanwhile
// (config writes still taken)
// a stalled receiver holds the result in the output register; the next transaction
// is still taken and worked on, and waits only at its own result
module video_sync_timer_with_register_file import vstr_pkg::*; #(
    parameter int REG_WORDS = REG_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    vstr_in_if.sink               in_ch,
    vstr_out_if.source            out_ch
);

    // configuration registers
    t_cfg r_cfg, n_cfg;

    // store port and shared adder between sequencer and their units
    t_mem_req    mem_req;
    logic [31:0] mem_rdata;
    logic        clear_busy;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;

    // config write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_CYCLES: n_cfg.frame_cycles    = i_cfg_wdata;
                CFG_LINES:        n_cfg.lines_per_frame = i_cfg_wdata[9:0];
                CFG_LINE_THR:     n_cfg.line_threshold  = i_cfg_wdata[15:0];
                CFG_LINE_STEP:    n_cfg.line_step       = i_cfg_wdata[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sequencer: accumulators, scanline, raster shadow, output register
    vstr_ctrl #(
        .REG_WORDS (REG_WORDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_clear_busy (clear_busy),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata),
        .o_alu_req    (alu_req),
        .i_alu_rsp    (alu_rsp),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

    // single add/subtract unit shared by the timing steps of the sequencer
    vstr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // single-port word store with clearing pass after reset
    vstr_store #(
        .REG_WORDS (REG_WORDS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (mem_req),
        .o_rdata      (mem_rdata),
        .o_clear_busy (clear_busy)
    );

endmodule
